// ----- rtl/dtc_pkg.sv -----
// ============================================================================
// dtc_pkg - shared types, constants and tables of the tone click generator
// Holds the widths of the tone datapath, the register and event codes, the
// sequencer state and control types, and the quarter-wave sine table.
// ============================================================================
package dtc_pkg;

    // Sizing
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int MAX_BURST_SAMPLES  = 4096;
    localparam int QUARTER_ENTRIES    = SINE_TABLE_ENTRIES / 4;
    localparam int QBITS              = $clog2(QUARTER_ENTRIES);
    localparam int TAB_IDX_W          = QBITS + 1;

    // Field and register widths
    localparam int PHASE_W = 32;
    localparam int STEP_W  = 31;
    localparam int LEN_W   = 12;
    localparam int VOL_W   = 7;
    localparam int SINE_W  = 15;
    localparam int SAMP_W  = 16;
    localparam int CNT16_W = 16;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;

    // Tone arithmetic widths; peak 5200 over 100 percent folds into a gain of 52
    localparam int SQ_W   = 2 * LEN_W;             // (n-i)^2 and n^2
    localparam int MV_W   = SINE_W + VOL_W;        // |sin| * volume
    localparam int GAIN_W = 6;                     // gain of 52
    localparam int T_W    = MV_W + GAIN_W;         // |sin| * volume * 52
    localparam int NUM_W  = T_W + SQ_W;            // full numerator
    localparam int DEN_W  = SINE_W + SQ_W;         // 32767 * n^2 < 2^39
    localparam int MUL_A_W = T_W;
    localparam int MUL_B_W = SQ_W;
    localparam int PROD_W  = NUM_W;
    localparam int Q_W     = 17;                   // quotient bits kept
    localparam int DIV_W   = DEN_W + Q_W - 1;
    localparam int STEP_CNT_W = $clog2(Q_W);

    // Arithmetic constants
    localparam longint unsigned SINE_ONE    = 64'd32767;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int unsigned PEAK_AMPLITUDE  = 5200;
    localparam int unsigned PERCENT_SCALE   = 100;
    localparam int unsigned PEAK_GAIN       = PEAK_AMPLITUDE / PERCENT_SCALE; // exact

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] TOKEN_STEP_RST = 31'd202574421;
    localparam logic [STEP_W-1:0] COMP_STEP_RST  = 31'd148035154;
    localparam logic [LEN_W-1:0]  TOKEN_LEN_RST  = 12'd198;
    localparam logic [LEN_W-1:0]  COMP_LEN_RST   = 12'd286;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOUND_EN    = 3'd0,
        CFG_VOLUME      = 3'd1,
        CFG_TOKEN_STEP  = 3'd2,
        CFG_COMP_STEP   = 3'd3,
        CFG_TOKEN_LEN   = 3'd4,
        CFG_COMP_LEN    = 3'd5
    } cfg_index_e;

    // Item operations and event kinds
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    localparam logic [KIND_W-1:0] EV_TOKEN       = 3'd0;
    localparam logic [KIND_W-1:0] EV_COMP_UPDATE = 3'd1;
    localparam logic [KIND_W-1:0] EV_COMP_COMMIT = 3'd2;

    // Shared multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_REM_SQ,
        MUL_MAG_VOL,
        MUL_LEN_SQ,
        MUL_TERM,
        MUL_DEN,
        MUL_NUM
    } mul_op_e;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RR,
        ST_MUL_MV,
        ST_MUL_NN,
        ST_MUL_T,
        ST_MUL_DEN,
        ST_MUL_NUM,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_DONE
    } seq_state_e;

    // Sequencer control to the datapath
    typedef struct packed {
        mul_op_e mul_op;
        logic    cap_r2;
        logic    cap_mv;
        logic    cap_nn;
        logic    cap_t;
        logic    cap_den;
        logic    div_load;
        logic    div_step;
        logic    done;
        logic    idle;
    } seq_ctl_t;

    // Quarter-wave sine table, Q15 magnitudes, built at elaboration
    typedef logic [SINE_W-1:0] qsine_tab_t [0:QUARTER_ENTRIES];

    // Divide a Taylor term by (2n)(2n+1)
    function automatic longint unsigned taylor_div(longint unsigned v, int n);
        longint unsigned res;
        case (n)
            1:       res = v / 64'd6;
            2:       res = v / 64'd20;
            3:       res = v / 64'd42;
            4:       res = v / 64'd72;
            5:       res = v / 64'd110;
            6:       res = v / 64'd156;
            default: res = v / 64'd210;
        endcase
        return res;
    endfunction

    // sin(x) for x in [0, pi/2] in Q30, rounded to Q15
    function automatic logic [SINE_W-1:0] sine_q15(longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = ($unsigned(sum) * SINE_ONE + (64'd1 << 29)) >> 30;
        if (r > SINE_ONE)
            r = SINE_ONE;
        return r[SINE_W-1:0];
    endfunction

    function automatic qsine_tab_t build_qsine();
        qsine_tab_t      tab;
        longint unsigned x;
        for (int j = 0; j <= QUARTER_ENTRIES; j++) begin
            x      = (HALF_PI_Q30 * 64'(j)) / QUARTER_ENTRIES;
            tab[j] = sine_q15(x);
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();

    // Length register to burst length: zero acts as one, clamp at the maximum
    function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (len == '0)
            res = LEN_W'(1);
        else if (int'(len) > MAX_BURST_SAMPLES)
            res = LEN_W'(MAX_BURST_SAMPLES);
        else
            res = len;
        return res;
    endfunction

endpackage

// ----- rtl/dtc_mul.sv -----
// ============================================================================
// dtc_mul - shared unsigned multiplier
// One multiplier with a registered product, reused for every product of a
// sample; the operands are selected by the caller each cycle.
// ============================================================================
module dtc_mul
    import dtc_pkg::*;
(
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0] op_b,
    output logic [PROD_W-1:0]  prod
);

    logic [MUL_A_W+MUL_B_W-1:0] full_prod;
    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W-1:0]          prod_next;

    // Full product, upper bits are zero for every operand pair used
    assign full_prod = op_a * op_b;
    assign prod_next = full_prod[PROD_W-1:0];

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/dtc_seq.sv -----
// ============================================================================
// dtc_seq - sample computation sequencer
// Steps the shared multiplier through the six products of one sample and
// then runs the restoring divider one quotient bit per cycle.
// ============================================================================
module dtc_seq
    import dtc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    output seq_ctl_t ctl
);

    seq_state_e              state_reg;
    seq_state_e              state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg;
    logic [STEP_CNT_W-1:0]   cnt_next;
    logic                    step_last;

    assign step_last = (cnt_reg == STEP_CNT_W'(Q_W - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (start) state_next = ST_MUL_RR;
            ST_MUL_RR:   state_next = ST_MUL_MV;
            ST_MUL_MV:   state_next = ST_MUL_NN;
            ST_MUL_NN:   state_next = ST_MUL_T;
            ST_MUL_T:    state_next = ST_MUL_DEN;
            ST_MUL_DEN:  state_next = ST_MUL_NUM;
            ST_MUL_NUM:  state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_STEP;
            ST_DIV_STEP: if (step_last) state_next = ST_DONE;
            ST_DONE:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Divider step counter
    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == ST_DIV_LOAD)
            cnt_next = '0;
        else if (state_reg == ST_DIV_STEP && !step_last)
            cnt_next = cnt_reg + STEP_CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Outputs: each multiply state issues one product; each after the first captures the one before
    always_comb begin
        ctl = '0;
        ctl.mul_op = MUL_NONE;
        case (state_reg)
            ST_IDLE:     ctl.idle = 1'b1;
            ST_MUL_RR:   ctl.mul_op = MUL_REM_SQ;
            ST_MUL_MV: begin
                ctl.mul_op = MUL_MAG_VOL;
                ctl.cap_r2 = 1'b1;
            end
            ST_MUL_NN: begin
                ctl.mul_op = MUL_LEN_SQ;
                ctl.cap_mv = 1'b1;
            end
            ST_MUL_T: begin
                ctl.mul_op = MUL_TERM;
                ctl.cap_nn = 1'b1;
            end
            ST_MUL_DEN: begin
                ctl.mul_op = MUL_DEN;
                ctl.cap_t  = 1'b1;
            end
            ST_MUL_NUM: begin
                ctl.mul_op  = MUL_NUM;
                ctl.cap_den = 1'b1;
            end
            ST_DIV_LOAD: ctl.div_load = 1'b1;
            ST_DIV_STEP: ctl.div_step = 1'b1;
            ST_DONE:     ctl.done     = 1'b1;
            default:     ctl.idle     = 1'b0;
        endcase
    end

    // A sample run starts only from idle and walks the products in order
    a_start_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_RR) |-> ($past(state_reg) == ST_IDLE && $past(start)))
        else $error("sample run entered without a start from idle");

endmodule

// ----- rtl/decaying_tone_click_generator_top.sv -----
// ============================================================================
// decaying_tone_click_generator_top - key-click tone burst generator
// Trigger items start sine bursts with a quadratic decay; tick items return
// one signed 16-bit PCM sample each.
// ============================================================================
// Usage:
//   Input channel s_*: s_tuser[0] is the operation (0 tick, 1 trigger),
//   s_tdata[2:0] the event kind. Each item gives exactly one result item on
//   m_*: m_tdata holds sample[15:0], tone_active[16], dropped_count[32:17].
//   Config channel cfg_*: cfg_index picks the register (0 enable, 1 volume,
//   2 token step, 3 composition step, 4 token length, 5 composition length),
//   cfg_ready is always high; other indexes are ignored. Write only while
//   no item is in flight.
//   Timing: triggers and ticks outside a burst give their result on the
//   next cycle, so one item per cycle while the receiver keeps up. A tick
//   inside a burst runs six passes through the shared multiplier, a
//   divider load, 17 restoring divide steps, one quotient bit each, and a
//   closing state that registers the signed, saturated result.
//   s_tready stays low meanwhile.
//   Reset (aresetn low, synchronous) clears the burst, the dropped count
//   and the output slot and restores the register defaults.
//   A stalled receiver holds the result in the output register; a new item
//   is taken only when that register is empty or being read the same cycle.
// ============================================================================
module decaying_tone_click_generator_top
    import dtc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [2:0] event_kind, rest zero
    input  logic [0:0]             s_tuser,   // [0] operation
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [15:0] sample, [16] tone_active,
                                              // [32:17] dropped_count, rest zero
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    seq_ctl_t              ctl;
    logic [PROD_W-1:0]     prod;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;

    logic                  in_acc;
    logic                  cfg_acc;
    logic                  in_op;
    logic [KIND_W-1:0]     in_kind;

    // configuration
    logic                  sound_en_reg,   sound_en_next;
    logic [VOL_W-1:0]      volume_reg,     volume_next;
    logic [STEP_W-1:0]     token_step_reg, token_step_next;
    logic [STEP_W-1:0]     comp_step_reg,  comp_step_next;
    logic [LEN_W-1:0]      token_len_reg,  token_len_next;
    logic [LEN_W-1:0]      comp_len_reg,   comp_len_next;

    // burst state
    logic                  burst_active_reg, burst_active_next;
    logic                  burst_comp_reg,   burst_comp_next;
    logic [LEN_W-1:0]      sample_index_reg, sample_index_next;
    logic [PHASE_W-1:0]    phase_reg,        phase_next;
    logic [CNT16_W-1:0]    dropped_reg,      dropped_next;

    // output slot
    logic                  m_tvalid_reg,  m_tvalid_next;
    logic [SAMP_W-1:0]     out_sample_reg, out_sample_next;
    logic                  out_active_reg, out_active_next;
    logic [CNT16_W-1:0]    out_dropped_reg, out_dropped_next;

    // tone datapath
    logic [LEN_W-1:0]      n_reg,   n_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [SINE_W-1:0]     mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [SQ_W-1:0]       r2_reg;
    logic [MV_W-1:0]       mv_reg;
    logic [SQ_W-1:0]       nn_reg;
    logic [T_W-1:0]        t_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DIV_W-1:0]      div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]      dsh_reg,     dsh_next;
    logic [Q_W-1:0]        q_reg,       q_next;

    logic [LEN_W-1:0]      cur_len;
    logic [STEP_W-1:0]     cur_step;
    logic [LEN_W-1:0]      idx_inc;
    logic                  tick_go;
    logic                  trig_ok;
    logic [1:0]            quad;
    logic [QBITS-1:0]      tab_k;
    logic [TAB_IDX_W-1:0]  tab_idx;
    logic                  div_ge;
    logic [SAMP_W-1:0]     final_sample;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign s_tready  = ctl.idle && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_op     = s_tuser[0];
    assign in_kind   = s_tdata[KIND_W-1:0];

    // ------------------------------------------------------------------
    // Units
    // ------------------------------------------------------------------
    dtc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tick_go),
        .ctl     (ctl)
    );

    dtc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.mul_op)
            MUL_REM_SQ: begin
                mul_a = MUL_A_W'(rem_reg);
                mul_b = MUL_B_W'(rem_reg);
            end
            MUL_MAG_VOL: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(volume_reg);
            end
            MUL_LEN_SQ: begin
                mul_a = MUL_A_W'(n_reg);
                mul_b = MUL_B_W'(n_reg);
            end
            MUL_TERM: begin
                mul_a = MUL_A_W'(mv_reg);
                mul_b = MUL_B_W'(PEAK_GAIN);
            end
            MUL_DEN: begin
                mul_a = MUL_A_W'(nn_reg);
                mul_b = MUL_B_W'(SINE_ONE);
            end
            MUL_NUM: begin
                mul_a = t_reg;
                mul_b = r2_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Item decode: burst selection, sine lookup, trigger qualification
    // ------------------------------------------------------------------
    assign cur_len  = eff_len(burst_comp_reg ? comp_len_reg : token_len_reg);
    assign cur_step = burst_comp_reg ? comp_step_reg : token_step_reg;
    assign idx_inc  = sample_index_reg + LEN_W'(1);
    assign tick_go  = in_acc && (in_op == OP_TICK) && burst_active_reg
                      && (sample_index_reg < cur_len);
    assign trig_ok  = sound_en_reg && (volume_reg != '0) && (in_kind <= EV_COMP_COMMIT);

    assign quad    = phase_reg[PHASE_W-1 -: 2];
    assign tab_k   = phase_reg[PHASE_W-3 -: QBITS];
    assign tab_idx = quad[0] ? (TAB_IDX_W'(QUARTER_ENTRIES) - {1'b0, tab_k})
                             : {1'b0, tab_k};

    // ------------------------------------------------------------------
    // Configuration and burst state update
    // ------------------------------------------------------------------
    always_comb begin
        sound_en_next     = sound_en_reg;
        volume_next       = volume_reg;
        token_step_next   = token_step_reg;
        comp_step_next    = comp_step_reg;
        token_len_next    = token_len_reg;
        comp_len_next     = comp_len_reg;
        burst_active_next = burst_active_reg;
        burst_comp_next   = burst_comp_reg;
        sample_index_next = sample_index_reg;
        phase_next        = phase_reg;
        dropped_next      = dropped_reg;

        // item effects
        if (in_acc) begin
            if (in_op == OP_TRIGGER) begin
                if (trig_ok) begin
                    if (burst_active_reg) begin
                        if (dropped_reg != '1)
                            dropped_next = dropped_reg + CNT16_W'(1);
                    end else begin
                        burst_active_next = 1'b1;
                        burst_comp_next   = (in_kind != EV_TOKEN);
                        sample_index_next = '0;
                        phase_next        = '0;
                    end
                end
            end else if (burst_active_reg) begin
                if (sample_index_reg >= cur_len) begin
                    burst_active_next = 1'b0;
                end else begin
                    phase_next        = phase_reg + PHASE_W'(cur_step);
                    sample_index_next = idx_inc;
                    burst_active_next = (idx_inc < cur_len);
                end
            end
        end

        // register writes; disabling or muting cancels a burst
        if (cfg_acc) begin
            case (cfg_index)
                CFG_SOUND_EN: begin
                    sound_en_next = cfg_data[0];
                    if (!cfg_data[0])
                        burst_active_next = 1'b0;
                end
                CFG_VOLUME: begin
                    volume_next = cfg_data[VOL_W-1:0];
                    if (cfg_data[VOL_W-1:0] == '0)
                        burst_active_next = 1'b0;
                end
                CFG_TOKEN_STEP: token_step_next = cfg_data[STEP_W-1:0];
                CFG_COMP_STEP:  comp_step_next  = cfg_data[STEP_W-1:0];
                CFG_TOKEN_LEN:  token_len_next  = cfg_data[LEN_W-1:0];
                CFG_COMP_LEN:   comp_len_next   = cfg_data[LEN_W-1:0];
                default:        sound_en_next   = sound_en_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_en_reg     <= 1'b0;
            volume_reg       <= '0;
            token_step_reg   <= TOKEN_STEP_RST;
            comp_step_reg    <= COMP_STEP_RST;
            token_len_reg    <= TOKEN_LEN_RST;
            comp_len_reg     <= COMP_LEN_RST;
            burst_active_reg <= 1'b0;
            burst_comp_reg   <= 1'b0;
            sample_index_reg <= '0;
            phase_reg        <= '0;
            dropped_reg      <= '0;
        end else begin
            sound_en_reg     <= sound_en_next;
            volume_reg       <= volume_next;
            token_step_reg   <= token_step_next;
            comp_step_reg    <= comp_step_next;
            token_len_reg    <= token_len_next;
            comp_len_reg     <= comp_len_next;
            burst_active_reg <= burst_active_next;
            burst_comp_reg   <= burst_comp_next;
            sample_index_reg <= sample_index_next;
            phase_reg        <= phase_next;
            dropped_reg      <= dropped_next;
        end
    end

    // ------------------------------------------------------------------
    // Tone datapath: operand capture and restoring divider
    // ------------------------------------------------------------------
    assign div_ge = (div_rem_reg >= dsh_reg);

    always_comb begin
        n_next       = n_reg;
        rem_next     = rem_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        div_rem_next = div_rem_reg;
        dsh_next     = dsh_reg;
        q_next       = q_reg;
        if (tick_go) begin
            n_next   = cur_len;
            rem_next = cur_len - sample_index_reg;
            mag_next = QSINE[tab_idx];
            neg_next = quad[1];
        end
        if (ctl.div_load) begin
            div_rem_next = DIV_W'(prod);
            dsh_next     = {den_reg, {(Q_W-1){1'b0}}};
            q_next       = '0;
        end else if (ctl.div_step) begin
            div_rem_next = div_ge ? (div_rem_reg - dsh_reg) : div_rem_reg;
            dsh_next     = dsh_reg >> 1;
            q_next       = {q_reg[Q_W-2:0], div_ge};
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        rem_reg     <= rem_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        div_rem_reg <= div_rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        if (ctl.cap_r2)
            r2_reg <= prod[SQ_W-1:0];
        if (ctl.cap_mv)
            mv_reg <= prod[MV_W-1:0];
        if (ctl.cap_nn)
            nn_reg <= prod[SQ_W-1:0];
        if (ctl.cap_t)
            t_reg <= prod[T_W-1:0];
        if (ctl.cap_den)
            den_reg <= prod[DEN_W-1:0];
    end

    // Sign and saturation of the quotient
    always_comb begin
        if (neg_reg) begin
            if (q_reg > Q_W'(32768))
                final_sample = 16'h8000;
            else
                final_sample = ~q_reg[SAMP_W-1:0] + SAMP_W'(1);
        end else begin
            if (q_reg > Q_W'(32767))
                final_sample = 16'h7FFF;
            else
                final_sample = q_reg[SAMP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output slot
    // ------------------------------------------------------------------
    always_comb begin
        m_tvalid_next    = m_tvalid_reg;
        out_sample_next  = out_sample_reg;
        out_active_next  = out_active_reg;
        out_dropped_next = out_dropped_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        if (in_acc && !tick_go) begin
            // triggers and silent ticks finish at once
            m_tvalid_next    = 1'b1;
            out_sample_next  = '0;
            out_active_next  = burst_active_next;
            out_dropped_next = dropped_next;
        end else if (ctl.done) begin
            m_tvalid_next    = 1'b1;
            out_sample_next  = final_sample;
            out_active_next  = burst_active_reg;
            out_dropped_next = dropped_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        out_sample_reg  <= out_sample_next;
        out_active_reg  <= out_active_next;
        out_dropped_reg <= out_dropped_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - SAMP_W - 1 - CNT16_W){1'b0}},
                       out_dropped_reg, out_active_reg, out_sample_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.done |-> !m_tvalid_reg)
        else $error("computed sample finished with the output slot occupied");

    a_accept_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> (!m_tvalid_reg || m_tready))
        else $error("item taken while an undelivered result is held");

    a_dropped_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (dropped_reg != $past(dropped_reg)) |->
            (dropped_reg == $past(dropped_reg) + CNT16_W'(1)))
        else $error("dropped count moved by other than one");

    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_load |-> (den_reg != '0))
        else $error("divider loaded with a zero divisor");

endmodule

// ----- bench/dtc_click_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// dtc_click_checker - result checker for the tone click generator
// Watches the input, result and register channels of the block. Keeps its own
// copy of the burst state and registers, works out the result of every
// accepted item and compares each result item field by field, in order.
// ============================================================================
module dtc_click_checker
    import dtc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,     // [2:0] event_kind, rest zero
    input  logic [0:0]            s_tuser,     // [0] operation
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,     // [15:0] sample, [16] tone_active,
                                               // [32:17] dropped_count, rest zero
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    awaited
);

    typedef longint unsigned u64_t;

    // quarter wave of a 1024-entry sine table
    localparam int   QUARTER     = 256;
    localparam u64_t UNITY       = 64'd32767;
    localparam u64_t Q30_HALF_PI = 64'd1686629713;
    localparam u64_t TONE_PEAK   = 64'd5200;
    localparam u64_t PCT_DIV     = 64'd100;

    typedef struct packed {
        logic [15:0] pcm;
        logic        active;
        logic [15:0] drops;
    } click_result_t;

    click_result_t expected_clicks[$];

    // registers
    logic        snd_en;
    logic [6:0]  vol;
    logic [30:0] tok_step;
    logic [30:0] comp_step;
    logic [11:0] tok_len;
    logic [11:0] comp_len;

    // burst state
    logic        playing;
    logic        comp_tone;
    logic [11:0] pos;
    logic [31:0] phase_acc;
    logic [15:0] drops;

    logic [14:0] quarter_wave [0:QUARTER];

    initial mismatches = 0;
    initial awaited    = 0;

    // Taylor series to 15th order, x in Q30 over [0, pi/2], rounded to Q15
    function automatic u64_t q15_sine(u64_t x);
        u64_t   x2;
        u64_t   term;
        u64_t   rounded;
        longint acc;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / u64_t'(2 * n * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (u64_t'(acc) * UNITY + (u64_t'(1) << 29)) >> 30;
        if (rounded > UNITY)
            rounded = UNITY;
        return rounded;
    endfunction

    initial begin
        for (int j = 0; j <= QUARTER; j++)
            quarter_wave[j] = 15'(q15_sine((Q30_HALF_PI * u64_t'(j)) / u64_t'(QUARTER)));
    end

    // sine of the phase times peak, volume and squared decay, truncated, clamped
    function automatic logic [15:0] decayed_pcm(logic [31:0] ph, u64_t n, u64_t rem,
                                                u64_t level);
        logic [8:0] slot;
        u64_t       mag;
        u64_t       num;
        u64_t       den;
        u64_t       q;
        longint     val;
        // odd quadrants run the table backwards, upper half is negative
        slot = ph[30] ? 9'(QUARTER) - {1'b0, ph[29:22]} : {1'b0, ph[29:22]};
        mag  = u64_t'(quarter_wave[slot]);
        num  = mag * TONE_PEAK * level * rem * rem;
        den  = UNITY * PCT_DIV * n * n;
        q    = num / den;
        if (ph[31]) begin
            if (q > 64'd32768)
                val = -64'sd32768;
            else
                val = -longint'(q);
        end else begin
            if (q > 64'd32767)
                val = 64'sd32767;
            else
                val = longint'(q);
        end
        return val[15:0];
    endfunction

    task automatic predict_item(input logic op, input logic [KIND_W-1:0] kind);
        click_result_t res;
        u64_t          n;
        res.pcm = '0;
        if (op == OP_TRIGGER) begin
            // kinds above composition-committed, disabled or silent: nothing
            if (snd_en && vol != '0 && kind <= EV_COMP_COMMIT) begin
                if (playing) begin
                    if (drops != 16'hFFFF)
                        drops = drops + 16'd1;
                end else begin
                    playing   = 1'b1;
                    comp_tone = (kind != EV_TOKEN);
                    pos       = '0;
                    phase_acc = '0;
                end
            end
        end else if (playing) begin
            // zero length acts as one; 12 bits never exceed the burst maximum
            n = u64_t'(comp_tone ? comp_len : tok_len);
            if (n == 0)
                n = 1;
            if (u64_t'(pos) >= n) begin
                // length shrunk below the index: silent end of burst
                playing = 1'b0;
            end else begin
                res.pcm   = decayed_pcm(phase_acc, n, n - u64_t'(pos), u64_t'(vol));
                phase_acc = phase_acc + (comp_tone ? comp_step : tok_step);
                pos       = pos + 12'd1;
                if (u64_t'(pos) >= n)
                    playing = 1'b0;
            end
        end
        res.active = playing;
        res.drops  = drops;
        expected_clicks.push_back(res);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        click_result_t want;
        if (!aresetn) begin
            snd_en    = 1'b0;
            vol       = '0;
            tok_step  = 31'd202574421;
            comp_step = 31'd148035154;
            tok_len   = 12'd198;
            comp_len  = 12'd286;
            playing   = 1'b0;
            comp_tone = 1'b0;
            pos       = '0;
            phase_acc = '0;
            drops     = '0;
            expected_clicks.delete();
        end else begin
            // register writes, only seen while nothing is in flight
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SOUND_EN: begin
                        snd_en = cfg_data[0];
                        if (!cfg_data[0])
                            playing = 1'b0;
                    end
                    CFG_VOLUME: begin
                        vol = cfg_data[6:0];
                        if (cfg_data[6:0] == '0)
                            playing = 1'b0;
                    end
                    CFG_TOKEN_STEP: tok_step  = cfg_data;
                    CFG_COMP_STEP:  comp_step = cfg_data;
                    CFG_TOKEN_LEN:  tok_len   = cfg_data[11:0];
                    CFG_COMP_LEN:   comp_len  = cfg_data[11:0];
                    default: ;
                endcase
            end

            // result side first: it belongs to an older item
            if (m_tvalid && m_tready) begin
                if (expected_clicks.size() == 0) begin
                    report("unexpected result item, tdata[31:0]", m_tdata[31:0], '0);
                end else begin
                    want = expected_clicks.pop_front();
                    if (m_tdata[15:0] !== want.pcm)
                        report("sample", 32'(m_tdata[15:0]), 32'(want.pcm));
                    if (m_tdata[16] !== want.active)
                        report("tone_active", 32'(m_tdata[16]), 32'(want.active));
                    if (m_tdata[32:17] !== want.drops)
                        report("dropped_count", 32'(m_tdata[32:17]), 32'(want.drops));
                    if (m_tdata[M_TDATA_W-1:33] !== '0)
                        report("tdata padding", 32'(m_tdata[M_TDATA_W-1:33]), '0);
                end
            end

            if (s_tvalid && s_tready)
                predict_item(s_tuser[0], s_tdata[KIND_W-1:0]);
        end
        awaited = expected_clicks.size();
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb - testbench of the decaying tone click generator
// Drives register writes and tick/trigger items with random idling on both
// sides: a directed opening, random bursts under changing settings, a held
// burst that refuses a run of triggers and a length shrunk below the index.
// A checker beside the block predicts and compares every result item.
// ============================================================================
module tb;
    import dtc_pkg::*;

    localparam int RUN_ITEMS     = 1200;
    localparam int HELD_TRIGGERS = 40;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 600000;

    // event kinds that start nothing
    localparam logic [KIND_W-1:0] EV_CLEARED    = 3'd3;
    localparam logic [KIND_W-1:0] EV_SUPPRESSED = 3'd4;
    localparam logic [KIND_W-1:0] EV_UNUSED     = 3'd7;

    // indexes past the register list
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [2:0] event_kind, rest zero
    logic [0:0]            s_tuser   = '0;   // [0] operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [15:0] sample, [16] tone_active,
                                             // [32:17] dropped_count, rest zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          mismatches;
    int          awaited;
    int          cycles      = 0;
    int          sent        = 0;
    logic        calm        = 1'b0;
    logic [11:0] tok_len_sh  = 12'd198;
    logic [11:0] comp_len_sh = 12'd286;

    decaying_tone_click_generator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dtc_click_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls at random, about a fifth of the time, never while calm
    always @(posedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 20);

    function automatic int tone_len(logic [11:0] r);
        return (r == '0) ? 1 : int'(r);
    endfunction

    // one item; sender gaps of random length ahead of it
    task automatic send_item(input logic op, input logic [KIND_W-1:0] kind);
        logic took;
        while (!calm && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - KIND_W){1'b0}}, kind};
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        sent++;
    endtask

    // register write; cfg_valid is lowered by the caller after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        logic took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        if (idx == CFG_TOKEN_LEN)
            tok_len_sh = data[11:0];
        if (idx == CFG_COMP_LEN)
            comp_len_sh = data[11:0];
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (awaited != 0);
        @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] step_value();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return 31'h7FFF_FFFF;
        else
            return 31'($urandom);
    endfunction

    // mostly short bursts, a few zero-length (played as one sample), long and full-size ones
    function automatic logic [CFG_DATA_W-1:0] len_value();
        int          roll;
        logic [11:0] len;
        roll = $urandom_range(99);
        if (roll < 70)
            len = 12'($urandom_range(24, 1));
        else if (roll < 80)
            len = '0;
        else if (roll < 90)
            len = 12'($urandom_range(300, 25));
        else
            len = $urandom_range(1) ? 12'hFFF : 12'($urandom);
        return {19'($urandom), len};
    endfunction

    task automatic pick_settings();
        logic [6:0] level;
        // a long burst left over gets cancelled now and then
        if ((tone_len(tok_len_sh) > 64 || tone_len(comp_len_sh) > 64) && $urandom_range(1)) begin
            write_reg(CFG_SOUND_EN, {30'($urandom), 1'b0});
            write_reg(CFG_SOUND_EN, {30'($urandom), 1'b1});
        end
        if ($urandom_range(99) < 60)
            write_reg(CFG_SOUND_EN, {30'($urandom), 1'($urandom_range(99) < 85)});
        if ($urandom_range(1)) begin
            case ($urandom_range(5))
                0:       level = 7'd0;
                1:       level = 7'd1;
                2:       level = 7'd100;
                3:       level = 7'd127;
                default: level = 7'($urandom_range(127));
            endcase
            write_reg(CFG_VOLUME, {24'($urandom), level});
        end
        if ($urandom_range(99) < 40)
            write_reg(CFG_TOKEN_STEP, step_value());
        if ($urandom_range(99) < 40)
            write_reg(CFG_COMP_STEP, step_value());
        if ($urandom_range(1))
            write_reg(CFG_TOKEN_LEN, len_value());
        if ($urandom_range(1))
            write_reg(CFG_COMP_LEN, len_value());
        if ($urandom_range(99) < 10)
            write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 31'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // mostly trigger-then-ticks bursts, the rest random items
    task automatic play_phase(input int budget);
        int                burst;
        int                ticks;
        int                done_items;
        logic [KIND_W-1:0] kind;
        done_items = 0;
        while (done_items < budget) begin
            if ($urandom_range(99) < 75) begin
                kind  = KIND_W'($urandom_range(2));
                burst = tone_len(kind == EV_TOKEN ? tok_len_sh : comp_len_sh);
                ticks = (burst > 64) ? $urandom_range(64, 8) : burst + $urandom_range(2);
                send_item(OP_TRIGGER, kind);
                for (int t = 0; t < ticks; t++) begin
                    // stray trigger inside the burst, usually refused
                    if ($urandom_range(99) < 4)
                        send_item(OP_TRIGGER, KIND_W'($urandom_range(7)));
                    send_item(OP_TICK, KIND_W'($urandom_range(7)));
                end
                done_items += ticks + 1;
            end else begin
                send_item(1'($urandom_range(1)), KIND_W'($urandom_range(7)));
                done_items++;
            end
        end
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // disabled after reset: no burst
        send_item(OP_TRIGGER, EV_TOKEN);
        send_item(OP_TICK, EV_TOKEN);
        drain();

        // enabled but silent
        write_reg(CFG_SOUND_EN, 31'd1);
        write_reg(CFG_VOLUME, 31'd0);
        cfg_valid <= 1'b0;
        send_item(OP_TRIGGER, EV_COMP_UPDATE);
        send_item(OP_TICK, EV_TOKEN);
        drain();

        write_reg(CFG_VOLUME, 31'd100);
        write_reg(CFG_TOKEN_STEP, 31'h7FFF_FFFF);
        write_reg(CFG_COMP_STEP, 31'd0);
        write_reg(CFG_TOKEN_LEN, 31'd4);
        write_reg(CFG_COMP_LEN, 31'd0);
        write_reg(CFG_SPARE_LO, '1);
        cfg_valid <= 1'b0;
        // cleared, suppressed and unknown kinds start nothing
        send_item(OP_TRIGGER, EV_CLEARED);
        send_item(OP_TRIGGER, EV_SUPPRESSED);
        send_item(OP_TRIGGER, EV_UNUSED);
        send_item(OP_TICK, EV_TOKEN);
        // token burst, two refused triggers, runs out after four ticks
        send_item(OP_TRIGGER, EV_TOKEN);
        send_item(OP_TRIGGER, EV_COMP_COMMIT);
        send_item(OP_TRIGGER, EV_COMP_UPDATE);
        repeat (5) send_item(OP_TICK, EV_TOKEN);
        // zero composition length plays a single sample
        send_item(OP_TRIGGER, EV_COMP_UPDATE);
        send_item(OP_TICK, EV_TOKEN);
        send_item(OP_TRIGGER, EV_COMP_COMMIT);
        send_item(OP_TICK, EV_TOKEN);
        drain();

        // volume above 100, full-size composition burst
        write_reg(CFG_VOLUME, 31'd127);
        write_reg(CFG_COMP_STEP, 31'h4000_0001);
        write_reg(CFG_COMP_LEN, 31'd4095);
        cfg_valid <= 1'b0;
        send_item(OP_TRIGGER, EV_COMP_COMMIT);
        repeat (3) send_item(OP_TICK, EV_TOKEN);
        drain();

        // random phases; one runs with no idling
        sent = 0;
        ph   = 0;
        while (sent < RUN_ITEMS) begin
            pick_settings();
            calm <= (ph == 4);
            play_phase($urandom_range(120, 50));
            drain();
            ph++;
        end

        // held burst, a run of refused triggers back to back
        calm <= 1'b1;
        write_reg(CFG_SOUND_EN, 31'd1);
        write_reg(CFG_VOLUME, 31'd100);
        write_reg(CFG_TOKEN_LEN, 31'd4095);
        cfg_valid <= 1'b0;
        send_item(OP_TRIGGER, EV_TOKEN);
        send_item(OP_TICK, EV_TOKEN);
        repeat (HELD_TRIGGERS) send_item(OP_TRIGGER, KIND_W'($urandom_range(2)));
        repeat (3) send_item(OP_TICK, EV_TOKEN);
        drain();

        // length shrunk below the index: the next tick ends the burst
        calm <= 1'b0;
        write_reg(CFG_TOKEN_LEN, 31'd2);
        cfg_valid <= 1'b0;
        repeat (2) send_item(OP_TICK, EV_TOKEN);
        drain();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
